FILE: hw/rtl/wmpb_pkg.sv
// shared widths, codes and types for the wavetable mip pyramid builder
package wmpb_pkg;

  localparam int SMP_W = 24;  // q1.23 sample
  localparam int LEN_W = 13;  // wave_length register and per-level sizes
  localparam int POS_W = 14;  // signed sample position
  localparam int LVL_W = 4;   // mip level field
  localparam int FUNC_W = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_BUILD = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_WAVE_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOOPED      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIP_ENABLE  = 2'd2;

  typedef logic signed [SMP_W-1:0] smp_t;
  typedef logic [LEN_W-1:0] len_t;

endpackage

FILE: hw/rtl/wavetable_mip_pyramid_builder_top.sv
// wavetable store with level-0 writes, mip pyramid build and padded reads
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in_     | slave     | in_tvalid/in_tready  | tdata: level, position, sample_in; tuser: func
//  out_    | master    | out_tvalid/out_tready| tdata: sample_out; tuser: status
//  cfg_    | slave     | cfg_valid/cfg_ready  | cfg_index, cfg_data (always ready)
//
// one transaction is in flight at a time; the result sits in an output register
// write, build with mip generation off and unused codes: the result is loaded on acceptance
// read inside a level: size lookup, range check, memory read, result;
// a read into looped padding adds the steps of the bit-serial remainder unit and a wrap step
// build: setup, left and center reads per level, then a read and a write step per generated
// sample, set by the single read port of the sample memory; input is held off until the walk ends
// rst_n is synchronous; the sample memory is not cleared and holds garbage until written
module wavetable_mip_pyramid_builder_top
  import wmpb_pkg::*;
#(
  parameter int MAX_LENGTH = 4096,
  parameter int NUM_LEVELS = 10,
  parameter int PAD_BEFORE = 16,
  parameter int PAD_AFTER  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input transactions
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [47:0]           in_tdata,   // [3:0] level, [17:4] position, [41:18] sample_in
  input  logic [FUNC_W-1:0]     in_tuser,   // [1:0] func
  // result transactions
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [SMP_W-1:0]      out_tdata,  // [23:0] sample_out
  output logic                  out_tuser,  // [0] status
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // memory geometry: level i starts at the sum of ceil(MAX_LENGTH/2^j), j < i
  localparam int DEPTH   = 2 * MAX_LENGTH + NUM_LEVELS;
  localparam int AW      = $clog2(DEPTH);
  localparam int PAD_MAX = (PAD_BEFORE > PAD_AFTER) ? PAD_BEFORE : PAD_AFTER;
  localparam int DW      = $clog2(PAD_MAX + 1);  // padding offset width
  localparam int CW      = $clog2(DW + 1);       // remainder step counter

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_R_SIZE  = 4'd1;
  localparam logic [3:0] ST_R_CHK   = 4'd2;
  localparam logic [3:0] ST_R_MOD   = 4'd3;
  localparam logic [3:0] ST_R_WRAP  = 4'd4;
  localparam logic [3:0] ST_R_DATA  = 4'd5;
  localparam logic [3:0] ST_B_SETUP = 4'd6;
  localparam logic [3:0] ST_B_L     = 4'd7;
  localparam logic [3:0] ST_B_C     = 4'd8;
  localparam logic [3:0] ST_B_R     = 4'd9;
  localparam logic [3:0] ST_B_W     = 4'd10;

  function automatic int base_of(int lvl);
    int b;
    b = 0;
    for (int j = 0; j < lvl; j++) begin
      b += (MAX_LENGTH + (1 << j) - 1) >> j;
    end
    return b;
  endfunction

  // ceil(len / 2^l)
  function automatic len_t lsize(len_t len, logic [LVL_W-1:0] l);
    len_t mask;
    mask = ~({LEN_W{1'b1}} << l);
    return (len >> l) + LEN_W'(|(len & mask));
  endfunction

  // level base table, one entry per level code
  logic [AW-1:0] base_tab [16];
  for (genvar g = 0; g < 16; g++) begin : g_base
    assign base_tab[g] = (g < NUM_LEVELS) ? AW'(base_of(g)) : '0;
  end

  // sample memory
  smp_t          mem [DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  smp_t          mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  smp_t          rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  // configuration registers
  len_t wave_length_r;
  logic looped_r;
  logic mip_en_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_length_r <= '0;
      looped_r      <= 1'b0;
      mip_en_r      <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WAVE_LENGTH: wave_length_r <= cfg_data;
        REG_LOOPED:      looped_r      <= cfg_data[0];
        REG_MIP_ENABLE:  mip_en_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // effective level-0 length saturates at MAX_LENGTH
  len_t eff_len;
  assign eff_len = (int'(wave_length_r) > MAX_LENGTH) ? LEN_W'(MAX_LENGTH) : wave_length_r;

  // input fields
  logic [LVL_W-1:0] f_level;
  logic [POS_W-1:0] f_pos;
  smp_t             f_sample;
  assign f_level  = in_tdata[3:0];
  assign f_pos    = in_tdata[17:4];
  assign f_sample = in_tdata[41:18];

  // control and datapath registers
  logic [3:0]       state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  smp_t             out_sample_r, out_sample_nxt;
  logic             out_status_r, out_status_nxt;
  logic [LVL_W-1:0] it_level_r, it_level_nxt;
  logic [POS_W-1:0] it_pos_r, it_pos_nxt;
  len_t             sz_r, sz_nxt;
  logic [AW-1:0]    base_r, base_nxt;
  logic             hi_side_r, hi_side_nxt;
  logic [DW-1:0]    d_r, d_nxt;
  logic [DW-1:0]    rem_r, rem_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [LVL_W-1:0] lvl_r, lvl_nxt;
  len_t             s_r, s_nxt;
  len_t             sz_prev_r, sz_prev_nxt;
  len_t             sz_cur_r, sz_cur_nxt;
  logic [AW-1:0]    base_prev_r, base_prev_nxt;
  logic [AW-1:0]    base_cur_r, base_cur_nxt;
  smp_t             l_r, l_nxt;
  smp_t             c_r, c_nxt;
  logic             rzero_r, rzero_nxt;
  logic             out_load;

  logic             in_acc;
  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);

  // combinational helpers
  logic signed [15:0] pos_x;
  logic signed [15:0] hi_lim;
  logic               lvl_bad;
  logic [DW:0]        trial;
  len_t               wrap_q;
  logic [LEN_W:0]     r_idx;
  smp_t               r_val;
  logic signed [25:0] tap_sum;
  len_t               sz_b_cur;

  assign pos_x   = {{2{it_pos_r[POS_W-1]}}, it_pos_r};
  assign hi_lim  = $signed({3'b000, sz_r}) + 16'(PAD_AFTER);
  assign lvl_bad = ({1'b0, it_level_r} >= 5'(NUM_LEVELS)) || (it_level_r != '0 && !mip_en_r);
  assign trial   = {rem_r, d_r[DW-1]};
  assign wrap_q  = hi_side_r ? LEN_W'(rem_r) : (sz_r - LEN_W'(1) - LEN_W'(rem_r));
  assign r_idx   = {s_r, 1'b1};
  assign r_val   = rzero_r ? '0 : rd_data_r;
  assign tap_sum = {c_r[SMP_W-1], c_r, 1'b0}
                 + {{2{l_r[SMP_W-1]}}, l_r}
                 + {{2{r_val[SMP_W-1]}}, r_val};
  assign sz_b_cur = lsize(eff_len, lvl_r);

  always_comb begin
    state_nxt      = state_r;
    out_sample_nxt = out_sample_r;
    out_status_nxt = out_status_r;
    it_level_nxt   = it_level_r;
    it_pos_nxt     = it_pos_r;
    sz_nxt         = sz_r;
    base_nxt       = base_r;
    hi_side_nxt    = hi_side_r;
    d_nxt          = d_r;
    rem_nxt        = rem_r;
    cnt_nxt        = cnt_r;
    lvl_nxt        = lvl_r;
    s_nxt          = s_r;
    sz_prev_nxt    = sz_prev_r;
    sz_cur_nxt     = sz_cur_r;
    base_prev_nxt  = base_prev_r;
    base_cur_nxt   = base_cur_r;
    l_nxt          = l_r;
    c_nxt          = c_r;
    rzero_nxt      = rzero_r;
    out_load       = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          it_level_nxt = f_level;
          it_pos_nxt   = f_pos;
          unique case (in_tuser)
            FUNC_WRITE: begin
              out_load       = 1'b1;
              out_sample_nxt = '0;
              if (!f_pos[POS_W-1] && (f_pos[LEN_W-1:0] < eff_len)) begin
                mem_we         = 1'b1;
                mem_waddr      = AW'(f_pos[LEN_W-1:0]);
                mem_wdata      = f_sample;
                out_status_nxt = 1'b0;
              end else begin
                out_status_nxt = 1'b1;
              end
            end
            FUNC_BUILD: begin
              lvl_nxt = LVL_W'(1);
              if (mip_en_r && NUM_LEVELS > 1) begin
                state_nxt = ST_B_SETUP;
              end else begin
                out_load       = 1'b1;
                out_sample_nxt = '0;
                out_status_nxt = 1'b0;
              end
            end
            FUNC_READ: begin
              state_nxt = ST_R_SIZE;
            end
            default: begin
              out_load       = 1'b1;
              out_sample_nxt = '0;
              out_status_nxt = 1'b1;
            end
          endcase
        end
      end

      ST_R_SIZE: begin
        sz_nxt    = lsize(eff_len, it_level_r);
        base_nxt  = base_tab[it_level_r];
        state_nxt = ST_R_CHK;
      end

      ST_R_CHK: begin
        priority if (lvl_bad || pos_x < -16'(PAD_BEFORE) || pos_x >= hi_lim) begin
          out_load       = 1'b1;
          out_sample_nxt = '0;
          out_status_nxt = 1'b1;
          state_nxt      = ST_IDLE;
        end else if (sz_r == '0 || (it_pos_r[POS_W-1] || it_pos_r[LEN_W-1:0] >= sz_r)
                     && !looped_r) begin
          // empty level, or padding without looping
          out_load       = 1'b1;
          out_sample_nxt = '0;
          out_status_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end else if (!it_pos_r[POS_W-1] && it_pos_r[LEN_W-1:0] < sz_r) begin
          mem_re    = 1'b1;
          mem_raddr = base_r + AW'(it_pos_r[LEN_W-1:0]);
          state_nxt = ST_R_DATA;
        end else begin
          // looped padding: offset past the edge, reduced modulo the level size
          hi_side_nxt = !it_pos_r[POS_W-1];
          d_nxt       = it_pos_r[POS_W-1] ? DW'(~it_pos_r)
                                          : DW'(it_pos_r - POS_W'(sz_r));
          rem_nxt     = '0;
          cnt_nxt     = CW'(DW);
          state_nxt   = ST_R_MOD;
        end
      end

      ST_R_MOD: begin
        if (LEN_W'(trial) >= sz_r) begin
          rem_nxt = DW'(LEN_W'(trial) - sz_r);
        end else begin
          rem_nxt = DW'(trial);
        end
        d_nxt   = d_r << 1;
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          state_nxt = ST_R_WRAP;
        end
      end

      ST_R_WRAP: begin
        mem_re    = 1'b1;
        mem_raddr = base_r + AW'(wrap_q);
        state_nxt = ST_R_DATA;
      end

      ST_R_DATA: begin
        out_load       = 1'b1;
        out_sample_nxt = rd_data_r;
        out_status_nxt = 1'b0;
        state_nxt      = ST_IDLE;
      end

      ST_B_SETUP: begin
        sz_prev_nxt   = lsize(eff_len, lvl_r - LVL_W'(1));
        sz_cur_nxt    = sz_b_cur;
        base_prev_nxt = base_tab[lvl_r - LVL_W'(1)];
        base_cur_nxt  = base_tab[lvl_r];
        s_nxt         = '0;
        if (sz_b_cur == '0) begin
          // every higher level is empty too
          out_load       = 1'b1;
          out_sample_nxt = '0;
          out_status_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end else begin
          state_nxt = ST_B_L;
        end
      end

      ST_B_L: begin
        // left neighbor of sample 0 wraps to the last sample of the source level when looped, else zero
        mem_re    = looped_r;
        mem_raddr = base_prev_r + AW'(sz_prev_r) - AW'(1);
        state_nxt = ST_B_C;
      end

      ST_B_C: begin
        l_nxt     = looped_r ? rd_data_r : '0;
        mem_re    = 1'b1;
        mem_raddr = base_prev_r + AW'({s_r, 1'b0});
        state_nxt = ST_B_R;
      end

      ST_B_R: begin
        c_nxt = rd_data_r;
        priority if (r_idx < {1'b0, sz_prev_r}) begin
          mem_re    = 1'b1;
          mem_raddr = base_prev_r + AW'(r_idx);
          rzero_nxt = 1'b0;
        end else if (looped_r) begin
          mem_re    = 1'b1;
          mem_raddr = base_prev_r;
          rzero_nxt = 1'b0;
        end else begin
          rzero_nxt = 1'b1;
        end
        state_nxt = ST_B_W;
      end

      ST_B_W: begin
        mem_we    = 1'b1;
        mem_waddr = base_cur_r + AW'(s_r);
        mem_wdata = tap_sum[SMP_W+1:2];
        l_nxt     = r_val;
        priority if (s_r + LEN_W'(1) < sz_cur_r) begin
          // next center sample read overlaps this write
          s_nxt     = s_r + LEN_W'(1);
          mem_re    = 1'b1;
          mem_raddr = base_prev_r + AW'({s_r + LEN_W'(1), 1'b0});
          state_nxt = ST_B_R;
        end else if ({1'b0, lvl_r} == 5'(NUM_LEVELS - 1)) begin
          out_load       = 1'b1;
          out_sample_nxt = '0;
          out_status_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end else begin
          lvl_nxt   = lvl_r + LVL_W'(1);
          state_nxt = ST_B_SETUP;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_sample_r <= out_sample_nxt;
    out_status_r <= out_status_nxt;
    it_level_r   <= it_level_nxt;
    it_pos_r     <= it_pos_nxt;
    sz_r         <= sz_nxt;
    base_r       <= base_nxt;
    hi_side_r    <= hi_side_nxt;
    d_r          <= d_nxt;
    rem_r        <= rem_nxt;
    cnt_r        <= cnt_nxt;
    lvl_r        <= lvl_nxt;
    s_r          <= s_nxt;
    sz_prev_r    <= sz_prev_nxt;
    sz_cur_r     <= sz_cur_nxt;
    base_prev_r  <= base_prev_nxt;
    base_cur_r   <= base_cur_nxt;
    l_r          <= l_nxt;
    c_r          <= c_nxt;
    rzero_r      <= rzero_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sample_r;
  assign out_tuser  = out_status_r;

  // a result never overwrites one that is still waiting
  a_no_result_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_tready))
    else $error("result register loaded while occupied");

  // the sequencer leaves idle only on an accepted transaction
  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && !in_acc) |=> state_r == ST_IDLE)
    else $error("left idle without an input transaction");

  // a build never writes into the level-0 region
  a_build_above_level0: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && state_r == ST_B_W) |-> mem_waddr >= base_tab[1])
    else $error("build wrote into level 0");

  // the remainder stays below the level size during the modulo steps
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_R_MOD |-> LEN_W'(rem_r) < sz_r)
    else $error("padding remainder out of range");

endmodule
